// ===== src/tsrd_pkg.sv =====
// Shared types and constants for the thumbstick radial deadzone block.
// No dependencies.
package tsrd_pkg;

  localparam logic [14:0] FULL_SCALE = 15'h7FFF;
  localparam int MAG_W = 15;
  localparam int AXIS_W = 16;
  localparam int SQ_W = 32;
  localparam logic [1:0] REG_DEADZONE = 2'd0;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
  } tsrd_axes_t;

  typedef struct packed {
    tsrd_axes_t       axes;
    logic [MAG_W-1:0] mag;
    logic             dz;
  } tsrd_mag_t;

  typedef struct packed {
    logic sat;
    logic neg;
    logic dz;
  } tsrd_fin_t;

endpackage

// ===== src/tsrd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on tsrd_pkg.
module tsrd_isqrt import tsrd_pkg::*; #(
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SQ_W-1:0]    in_val,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [SQ_W/2-1:0]  out_root,
  output logic [SW-1:0]      out_side
);

  localparam int NS = SQ_W / 2;

  logic [SQ_W-1:0] v_q [NS];
  logic [SQ_W-1:0] r_q [NS];
  logic            vld [NS];
  logic [SW-1:0]   side [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] v_in, r_in, trial, v_next, r_next;
    logic            vld_in;
    logic [SW-1:0]   side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_val;
      assign r_in    = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_q[k-1];
      assign r_in    = r_q[k-1];
      assign vld_in  = vld[k-1];
      assign side_in = side[k-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if (v_in >= trial) begin
        v_next = v_in - trial;
        r_next = (r_in >> 1) + BIT;
      end else begin
        v_next = v_in;
        r_next = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[k]  <= v_next;
        r_q[k]  <= r_next;
        side[k] <= side_in;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_root  = r_q[NS-1][SQ_W/2-1:0];
  assign out_side  = side[NS-1];

endmodule

// ===== src/tsrd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tsrd_pkg; the caller keeps num below den shifted by QW.
module tsrd_div import tsrd_pkg::*; #(
  parameter int DW = 15,
  parameter int QW = 15,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DW+QW-1:0]   num,
  input  logic [DW-1:0]      den,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      out_side
);

  localparam int NW = DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic          vld   [QW];
  logic [SW-1:0] side  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int S = QW - 1 - k;
    logic [NW-1:0] rem_in, shifted, rem_next;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in, q_next;
    logic          vld_in;
    logic [SW-1:0] side_in;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign q_in    = q_q[k-1];
      assign vld_in  = vld[k-1];
      assign side_in = side[k-1];
    end

    always_comb begin
      shifted = NW'(den_in) << S;
      if (rem_in >= shifted) begin
        rem_next = rem_in - shifted;
        q_next   = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_next = rem_in;
        q_next   = {q_in[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_next;
        den_q[k] <= den_in;
        q_q[k]   <= q_next;
        side[k]  <= side_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = q_q[QW-1];
  assign out_side  = side[QW-1];

endmodule

// ===== src/thumbstick_radial_deadzone.sv =====
// Top level of the thumbstick radial deadzone: magnitude, rescale, per-axis scaling.
// Depends on tsrd_pkg, tsrd_isqrt and tsrd_div.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, stick_x, stick_y      | sample in
//   out     | out_valid, out_stall, scaled_x, scaled_y,  | result out
//           | in_deadzone                               |
//   cfg     | psel, penable, pwrite, paddr, pwdata,     | register port
//           | prdata, pready                            |
//
// One word per cycle unless the pipeline holds (see below); 52 register stages.
// Depth is set by the square root (16 stages) and the scale and per-axis dividers (15 stages each).
// The whole pipeline advances together; it holds while out_valid is high and out_stall is set.
// Synchronous reset clears all valid bits and sets deadzone_radius to 0.
module thumbstick_radial_deadzone import tsrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [AXIS_W-1:0] stick_x,
  input  logic signed [AXIS_W-1:0] stick_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [AXIS_W-1:0] scaled_x,
  output logic signed [AXIS_W-1:0] scaled_y,
  output logic                     in_deadzone,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic             en;
  logic [MAG_W-1:0] deadzone_radius;

  assign pready = 1'b1;
  assign en     = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_radius <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2:1] == REG_DEADZONE) begin
      deadzone_radius <= pwdata[MAG_W-1:0];
    end
  end

  assign prdata = (paddr[2:1] == REG_DEADZONE) ? {17'd0, deadzone_radius} : 32'd0;

  // abs stage
  logic       s1_valid;
  tsrd_axes_t s1_axes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_axes.neg_x <= stick_x[AXIS_W-1];
      s1_axes.neg_y <= stick_y[AXIS_W-1];
      s1_axes.ax    <= stick_x[AXIS_W-1] ? AXIS_W'(-stick_x) : stick_x;
      s1_axes.ay    <= stick_y[AXIS_W-1] ? AXIS_W'(-stick_y) : stick_y;
    end
  end

  // squares
  logic            s2_valid;
  tsrd_axes_t      s2_axes;
  logic [SQ_W-1:0] s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_axes <= s1_axes;
      s2_sum  <= (SQ_W'(s1_axes.ax) * SQ_W'(s1_axes.ax))
               + (SQ_W'(s1_axes.ay) * SQ_W'(s1_axes.ay));
    end
  end

  logic              rt_valid;
  logic [SQ_W/2-1:0] rt_root;
  tsrd_axes_t        rt_axes;

  tsrd_isqrt #(.SW($bits(tsrd_axes_t))) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_val    (s2_sum),
    .in_side   (s2_axes),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_axes)
  );

  // clamp, deadzone compare, rescale numerator and denominator
  logic [MAG_W-1:0]   mag_c;
  logic [MAG_W-1:0]   diff;
  logic               s3_valid;
  tsrd_mag_t          s3_info;
  logic [2*MAG_W-1:0] s3_num;
  logic [MAG_W-1:0]   s3_den;

  assign mag_c = (rt_root > {1'b0, FULL_SCALE}) ? FULL_SCALE : rt_root[MAG_W-1:0];
  assign diff  = mag_c - deadzone_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_info.axes <= rt_axes;
      s3_info.mag  <= mag_c;
      s3_info.dz   <= (mag_c <= deadzone_radius);
      s3_num       <= {diff, {MAG_W{1'b0}}} - (2*MAG_W)'(diff);
      s3_den       <= FULL_SCALE - deadzone_radius;
    end
  end

  logic             sc_valid;
  logic [MAG_W-1:0] sc_scale;
  tsrd_mag_t        sc_info;

  tsrd_div #(.DW(MAG_W), .QW(MAG_W), .SW($bits(tsrd_mag_t))) u_div_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .num       (s3_num),
    .den       (s3_den),
    .in_side   (s3_info),
    .out_valid (sc_valid),
    .quot      (sc_scale),
    .out_side  (sc_info)
  );

  // axis times scale
  localparam int PW = AXIS_W + MAG_W;
  logic          s4_valid;
  tsrd_mag_t     s4_info;
  logic [PW-1:0] s4_nx, s4_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_info <= sc_info;
      s4_nx   <= PW'(sc_info.axes.ax) * PW'(sc_scale);
      s4_ny   <= PW'(sc_info.axes.ay) * PW'(sc_scale);
    end
  end

  // saturation check against mag * 2^15
  logic               s5_valid;
  logic [MAG_W-1:0]   s5_mag;
  tsrd_fin_t          s5_fx;
  logic [1:0]         s5_fy;
  logic [2*MAG_W-1:0] s5_nx, s5_ny;
  logic [PW-1:0]      lim;

  assign lim = {1'b0, s4_info.mag, {MAG_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_mag    <= s4_info.mag;
      s5_fx.sat <= (s4_nx >= lim);
      s5_fx.neg <= s4_info.axes.neg_x;
      s5_fx.dz  <= s4_info.dz;
      s5_fy     <= {(s4_ny >= lim), s4_info.axes.neg_y};
      s5_nx     <= s4_nx[2*MAG_W-1:0];
      s5_ny     <= s4_ny[2*MAG_W-1:0];
    end
  end

  logic             dx_valid, dy_valid;
  logic [MAG_W-1:0] qx, qy;
  tsrd_fin_t        fx;
  logic [1:0]       fy;

  tsrd_div #(.DW(MAG_W), .QW(MAG_W), .SW($bits(tsrd_fin_t))) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num       (s5_nx),
    .den       (s5_mag),
    .in_side   (s5_fx),
    .out_valid (dx_valid),
    .quot      (qx),
    .out_side  (fx)
  );

  tsrd_div #(.DW(MAG_W), .QW(MAG_W), .SW(2)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num       (s5_ny),
    .den       (s5_mag),
    .in_side   (s5_fy),
    .out_valid (dy_valid),
    .quot      (qy),
    .out_side  (fy)
  );

  // saturate, restore sign, force zero in deadzone
  logic [MAG_W-1:0]  mx, my;
  logic [AXIS_W-1:0] rx, ry;

  assign mx = fx.sat ? FULL_SCALE : qx;
  assign my = fy[1]  ? FULL_SCALE : qy;
  assign rx = fx.neg ? AXIS_W'(-{1'b0, mx}) : {1'b0, mx};
  assign ry = fy[0]  ? AXIS_W'(-{1'b0, my}) : {1'b0, my};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_x    <= fx.dz ? '0 : rx;
      scaled_y    <= fx.dz ? '0 : ry;
      in_deadzone <= fx.dz;
    end
  end

endmodule

// ===== src/tsrd_checker.sv =====
// Port-level checks for thumbstick_radial_deadzone, bound to the top level.
// Depends on the top level's ports only.
module tsrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] scaled_x,
  input logic [15:0] scaled_y,
  input logic        in_deadzone
);

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_deadzone |-> scaled_x == 16'd0 && scaled_y == 16'd0)
    else $error("deadzone word with nonzero axes");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scaled_x != 16'h8000 && scaled_y != 16'h8000)
    else $error("axis beyond saturation limit");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input held without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scaled_x) && $stable(scaled_y))
    else $error("stalled word changed");

endmodule

bind thumbstick_radial_deadzone tsrd_checker u_tsrd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .scaled_x    (scaled_x),
  .scaled_y    (scaled_y),
  .in_deadzone (in_deadzone)
);

// ===== tb/testbench.sv =====
// Self-checking bench for the thumbstick radial deadzone: directed table, radius edge cases, then random samples.
// Expected words come from an integer predictor of the magnitude, rescale and saturation.
// Depends on tsrd_pkg and thumbstick_radial_deadzone.
module testbench;
  import tsrd_pkg::*;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               dz;
  } stick_word_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               known;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               dz;
  } table_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] stick_x = 0;
  logic signed [15:0] stick_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] scaled_x;
  logic signed [15:0] scaled_y;
  logic in_deadzone;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  logic [14:0] radius = 0;
  stick_word_t pending_words[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  table_row_t rows[$];

  thumbstick_radial_deadzone dut (.*);

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] root_floor(logic [31:0] v);
    logic [31:0] res;
    logic [31:0] bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] stretch_axis(logic signed [15:0] a,
                                                      logic [31:0] sc, logic [31:0] m);
    logic [63:0] mag_a;
    logic [63:0] q;
    mag_a = (a < 0) ? 64'(-32'(a)) : 64'(a);
    q = (mag_a * sc) / m;
    if (q > 32767) q = 32767;
    return (a < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic stick_word_t predict_stick(logic signed [15:0] x, logic signed [15:0] y);
    stick_word_t w;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] m;
    logic [31:0] sc;
    w.sx = x;
    w.sy = y;
    ax = (x < 0) ? 32'(-32'(x)) : 32'(x);
    ay = (y < 0) ? 32'(-32'(y)) : 32'(y);
    m = root_floor(ax * ax + ay * ay);
    if (m > 32767) m = 32767;
    if (m <= radius) begin
      w.ox = 0;
      w.oy = 0;
      w.dz = 1;
    end else begin
      sc = 32'((64'(m - radius) * 32767) / (32767 - radius));
      w.ox = stretch_axis(x, sc, m);
      w.oy = stretch_axis(y, sc, m);
      w.dz = 0;
    end
    return w;
  endfunction

  task automatic write_radius(logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= 3'(REG_DEADZONE) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    radius = v[14:0];
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_stick(logic signed [15:0] x, logic signed [15:0] y);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    stick_x <= x;
    stick_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(predict_stick(x, y));
  endtask

  task automatic add_row(int x, int y, bit k, int ox, int oy, bit d);
    table_row_t r;
    r.sx = 16'(x);
    r.sy = 16'(y);
    r.known = k;
    r.ox = 16'(ox);
    r.oy = 16'(oy);
    r.dz = d;
    rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) out_stall <= !calm && ($urandom_range(99) < 37);
    if (!rst && out_valid && !out_stall) begin
      stick_word_t w;
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word x=%0d y=%0d", $time, scaled_x, scaled_y);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (scaled_x !== w.ox || scaled_y !== w.oy || in_deadzone !== w.dz) begin
          $display("%0t in=(%0d,%0d) expected %0d %0d %0d actual %0d %0d %0d", $time,
                   w.sx, w.sy, w.ox, w.oy, w.dz, scaled_x, scaled_y, in_deadzone);
          errors++;
        end
      end
    end
  end

  initial begin
    int radii[6] = '{0, 1, 1000, 16384, 32766, 32767};
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0] rv;
    stick_word_t pw;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_row(0, 0, 1, 0, 0, 1);
    add_row(32767, 0, 1, 32767, 0, 0);
    add_row(-32768, 0, 1, -32767, 0, 0);
    add_row(0, 32767, 1, 0, 32767, 0);
    add_row(0, -32768, 1, 0, -32767, 0);
    add_row(1, 0, 1, 1, 0, 0);
    add_row(-1, 0, 1, -1, 0, 0);
    add_row(32767, 32767, 1, 32767, 32767, 0);
    add_row(-32768, -32768, 1, -32767, -32767, 0);
    add_row(32767, -32768, 1, 32767, -32767, 0);
    add_row(3, 4, 0, 0, 0, 0);
    add_row(-20000, 15000, 0, 0, 0, 0);
    add_row(100, -7, 0, 0, 0, 0);
    foreach (rows[i]) begin
      pw = predict_stick(rows[i].sx, rows[i].sy);
      if (rows[i].known && (pw.ox !== rows[i].ox || pw.oy !== rows[i].oy ||
                            pw.dz !== rows[i].dz)) begin
        $display("%0t table row %0d expected %0d %0d %0d actual %0d %0d %0d", $time, i,
                 rows[i].ox, rows[i].oy, rows[i].dz, pw.ox, pw.oy, pw.dz);
        errors++;
      end
      send_stick(rows[i].sx, rows[i].sy);
    end
    drain();
    write_radius(32'hFFFF_FFFF);
    send_stick(-32768, 32767);
    send_stick(30000, 10000);
    drain();
    write_radius(32766);
    send_stick(32767, 0);
    send_stick(-32768, -32768);
    send_stick(0, 32766);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      rv = (ph < 6) ? 32'(radii[ph]) : ($urandom() | 32'h8000);
      if (ph == 6) rv = $urandom();
      write_radius(rv);
      calm = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(3))
          0: begin x = $urandom(); y = $urandom(); end
          1: begin
            x = $signed(16'($urandom_range(2 * radius + 4))) - $signed(16'(radius)) - 2;
            y = $signed(16'($urandom_range(64))) - 32;
          end
          2: begin
            x = $urandom_range(1) ? 16'sh7FFF - $urandom_range(40)
                                  : -16'sh8000 + $urandom_range(40);
            y = $urandom();
          end
          default: begin x = $signed(16'($urandom_range(200))) - 100; y = $urandom(); end
        endcase
        send_stick(x, y);
      end
      calm = 0;
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tsrd_pkg.sv
src/tsrd_isqrt.sv
src/tsrd_div.sv
src/thumbstick_radial_deadzone.sv
src/tsrd_checker.sv
tb/testbench.sv
